@@ src/ctp_pkg.sv @@
// ----------------------------------------------------------------------------
// ctp_pkg: shared types and constants for the cartesian to polar converter
// Holds the arctangent table, gain correction factor, fixed angle codes and
// the per-transaction tag that travels alongside the CORDIC datapath.
// ----------------------------------------------------------------------------
package ctp_pkg;

	// default configuration
	localparam int DEF_CORDIC_STAGES = 16;
	localparam int DEF_DATA_WIDTH    = 16;

	// fraction bits added below the integer input
	localparam int GUARD_BITS = 14;

	// angle accumulator width, 2^32 units per turn
	localparam int ZW = 32;

	// number of table entries available
	localparam int ATAN_LEN = 24;

	// result field widths
	localparam int MOD_W = 16;
	localparam int ANG_W = 16;

	// 1/K in Q32
	localparam logic [31:0] INV_GAIN = 32'd2608131496;

	// accumulator angle limits
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
	localparam logic [31:0] ANG_ROUND    = 32'h0000_8000;

	// output angle codes for points on the axes
	localparam logic [ANG_W-1:0] ANG_POS_RE = 16'd0;
	localparam logic [ANG_W-1:0] ANG_POS_IM = 16'd16384;
	localparam logic [ANG_W-1:0] ANG_NEG_RE = 16'd32768;
	localparam logic [ANG_W-1:0] ANG_NEG_IM = 16'd49152;

	// modulus saturation limit
	localparam logic [MOD_W-1:0] MOD_MAX = 16'hFFFF;

	// round(atan(2^-i) / (2pi) * 2^32)
	localparam logic [31:0] ATAN_TURNS [0:ATAN_LEN-1] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10680094,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	// side information carried with each transaction
	typedef struct packed {
		logic             axis;     // point on an axis or the origin
		logic             zero;     // origin
		logic             re_neg;
		logic             im_neg;
		logic [MOD_W-1:0] ax_mod;   // modulus for axis points
		logic [ANG_W-1:0] ax_ang;   // angle for axis points
	} ctp_tag_t;

endpackage

@@ src/ctp_cell.sv @@
// ----------------------------------------------------------------------------
// ctp_cell: one CORDIC vectoring iteration
// Rotates (x, y) toward the positive real axis by atan(2^-SHIFT), updates the
// angle accumulator and holds the result in its own register stage.
// ----------------------------------------------------------------------------
module ctp_cell #(
	parameter int XW    = 33,
	parameter int SHIFT = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [XW-1:0]       in_x,
	input  logic signed [XW-1:0]       in_y,
	input  logic signed [ctp_pkg::ZW-1:0] in_z,
	input  ctp_pkg::ctp_tag_t          in_tag,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [XW-1:0]       out_x,
	output logic signed [XW-1:0]       out_y,
	output logic signed [ctp_pkg::ZW-1:0] out_z,
	output ctp_pkg::ctp_tag_t          out_tag
);
	import ctp_pkg::*;

	logic signed [XW-1:0] dx, dy, nx, ny;
	logic signed [ZW-1:0] step, nz;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	ctp_tag_t             tag_q;
	logic                 valid_q;
	logic                 load;

	// shifted cross terms, floor shifts
	assign dx   = in_y >>> SHIFT;
	assign dy   = in_x >>> SHIFT;
	assign step = signed'(ATAN_TURNS[SHIFT]);

	// rotate toward y = 0
	always_comb begin
		if (!in_y[XW-1]) begin
			nx = in_x + dx;
			ny = in_y - dy;
			nz = in_z + step;
		end else begin
			nx = in_x - dx;
			ny = in_y + dy;
			nz = in_z - step;
		end
	end

	// stage handshake, stage refills as soon as downstream takes its transaction
	assign in_ready = !valid_q || out_ready;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			x_q   <= nx;
			y_q   <= ny;
			z_q   <= nz;
			tag_q <= in_tag;
		end
	end

	assign out_valid = valid_q;
	assign out_x     = x_q;
	assign out_y     = y_q;
	assign out_z     = z_q;
	assign out_tag   = tag_q;

endmodule

@@ src/ctp_post.sv @@
// ----------------------------------------------------------------------------
// ctp_post: gain correction and angle unfolding
// Stage one multiplies x by 1/K in two partial products and maps the first
// quadrant angle back to its quadrant; stage two sums, rounds and saturates
// the modulus and holds the result for the output channel.
// ----------------------------------------------------------------------------
module ctp_post #(
	parameter int XW = 33
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [XW-1:0]          in_x,
	input  logic signed [ctp_pkg::ZW-1:0] in_z,
	input  ctp_pkg::ctp_tag_t             in_tag,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ctp_pkg::MOD_W-1:0]     out_modulus,
	output logic [ctp_pkg::ANG_W-1:0]     out_angle,
	output logic                          out_zero
);
	import ctp_pkg::*;

	// positive part of x, high slice from bit 16 up, product and sum widths
	localparam int UW  = XW - 1;
	localparam int HW  = UW - 16;
	localparam int HPW = HW + 32;
	localparam int LPW = 48;
	localparam int AW  = (HW + 33 > 46) ? HW + 33 : 46;
	localparam int MW  = AW - 30;

	logic [UW-1:0]        ux;
	logic [HPW-1:0]       hi_prod;
	logic [LPW-1:0]       lo_prod;
	logic [31:0]          zc, a, t, tr;
	logic [AW-1:0]        acc, rnd;
	logic [MW-1:0]        mag;
	logic [MOD_W-1:0]     mod_sat;

	logic [HPW-1:0]       hi_s1;
	logic [LPW-1:0]       lo_s1;
	logic [ANG_W-1:0]     ang_s1;
	ctp_tag_t             tag_s1;
	logic                 valid_s1;
	logic                 ready_s1;

	logic [MOD_W-1:0]     mod_q;
	logic [ANG_W-1:0]     ang_q;
	logic                 zero_q;
	logic                 valid_q;
	logic                 ready_q;

	// split gain multiply
	assign ux      = (in_x > 0) ? in_x[UW-1:0] : '0;
	assign hi_prod = HPW'(ux[UW-1:16]) * HPW'(INV_GAIN);
	assign lo_prod = LPW'(ux[15:0]) * LPW'(INV_GAIN);

	// clamp first quadrant angle to [0, quarter turn]
	assign zc = in_z[ZW-1] ? 32'd0 : 32'(in_z);
	assign a  = (zc > QUARTER_TURN) ? QUARTER_TURN : zc;

	// unfold into the source quadrant, modulo a full turn
	always_comb begin
		case ({in_tag.re_neg, in_tag.im_neg})
			2'b00:   t = a;
			2'b10:   t = HALF_TURN - a;
			2'b11:   t = HALF_TURN + a;
			default: t = 32'd0 - a;
		endcase
	end

	// round to 2^16 units per turn
	assign tr = t + ANG_ROUND;

	// stage one
	assign ready_s1 = !valid_s1 || ready_q;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			hi_s1  <= hi_prod;
			lo_s1  <= lo_prod;
			ang_s1 <= tr[31:16];
			tag_s1 <= in_tag;
		end
	end

	// sum partial products, round half up at the guard point, saturate
	assign acc     = AW'(hi_s1) + AW'(lo_s1[LPW-1:16]);
	assign rnd     = acc + (AW'(1) << (15 + GUARD_BITS));
	assign mag     = rnd[AW-1:30];
	assign mod_sat = (mag > MW'(MOD_MAX)) ? MOD_MAX : mag[MOD_W-1:0];

	// output register
	assign ready_q = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_q) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_q) begin
			mod_q  <= tag_s1.axis ? tag_s1.ax_mod : mod_sat;
			ang_q  <= tag_s1.axis ? tag_s1.ax_ang : ang_s1;
			zero_q <= tag_s1.zero;
		end
	end

	assign out_valid   = valid_q;
	assign out_modulus = mod_q;
	assign out_angle   = ang_q;
	assign out_zero    = zero_q;

endmodule

@@ src/cartesian_to_polar.sv @@
// register order: input stage, one per CORDIC iteration, ctp_post stage one, output register
// throughput: one transaction per cycle while not stalled, one register stage per iteration
// each stage refills while a later one is stalled, so bubbles close up under backpressure
// reset: arst_n clears all stage valid flags; payload registers are not reset
// ----------------------------------------------------------------------------
// cartesian_to_polar: pipelined CORDIC vectoring conversion
// Converts a signed complex sample to gain corrected modulus and an angle in
// turns. Axis points and the origin bypass the CORDIC result via a side tag.
// ----------------------------------------------------------------------------
module cartesian_to_polar #(
	parameter int CORDIC_STAGES = ctp_pkg::DEF_CORDIC_STAGES,
	parameter int DATA_WIDTH    = ctp_pkg::DEF_DATA_WIDTH
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// real_part, imag_part, zero padding to whole bytes
	input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]       s_tdata,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// modulus, angle
	output logic [31:0]                             m_tdata,
	// zero_input
	output logic                                    m_tuser
);
	import ctp_pkg::*;

	localparam int DW   = DATA_WIDTH;
	localparam int XW   = DW + GUARD_BITS + 3;
	localparam int ITER = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

	logic signed [DW-1:0] re, im;
	logic [DW-1:0]        abs_re, abs_im;
	logic [32:0]          ext_re, ext_im;
	logic [MOD_W-1:0]     sat_re, sat_im;
	ctp_tag_t             tag_in;

	logic signed [XW-1:0] x_s0, y_s0;
	ctp_tag_t             tag_s0;
	logic                 valid_s0;

	logic                 cvalid [0:ITER];
	logic                 cready [0:ITER];
	logic signed [XW-1:0] cx [0:ITER];
	logic signed [XW-1:0] cy [0:ITER];
	logic signed [ZW-1:0] cz [0:ITER];
	ctp_tag_t             ctag [0:ITER];

	logic [MOD_W-1:0]     modulus;
	logic [ANG_W-1:0]     angle;

	// unpack and take magnitudes
	assign re     = s_tdata[DW-1:0];
	assign im     = s_tdata[2*DW-1:DW];
	assign abs_re = re[DW-1] ? DW'(-re) : DW'(re);
	assign abs_im = im[DW-1] ? DW'(-im) : DW'(im);
	assign ext_re = 33'(abs_re);
	assign ext_im = 33'(abs_im);
	assign sat_re = (ext_re > 33'(MOD_MAX)) ? MOD_MAX : ext_re[MOD_W-1:0];
	assign sat_im = (ext_im > 33'(MOD_MAX)) ? MOD_MAX : ext_im[MOD_W-1:0];

	// classify axis points and the origin
	always_comb begin
		tag_in.axis   = (re == '0) || (im == '0);
		tag_in.zero   = (re == '0) && (im == '0);
		tag_in.re_neg = re[DW-1];
		tag_in.im_neg = im[DW-1];
		if (im == '0) begin
			tag_in.ax_mod = sat_re;
			tag_in.ax_ang = re[DW-1] ? ANG_NEG_RE : ANG_POS_RE;
		end else begin
			tag_in.ax_mod = sat_im;
			tag_in.ax_ang = im[DW-1] ? ANG_NEG_IM : ANG_POS_IM;
		end
	end

	// input stage
	assign s_tready = !valid_s0 || cready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (s_tready) begin
			valid_s0 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			x_s0   <= signed'({3'b000, abs_re, GUARD_BITS'(0)});
			y_s0   <= signed'({3'b000, abs_im, GUARD_BITS'(0)});
			tag_s0 <= tag_in;
		end
	end

	assign cvalid[0] = valid_s0;
	assign cx[0]     = x_s0;
	assign cy[0]     = y_s0;
	assign cz[0]     = '0;
	assign ctag[0]   = tag_s0;

	// chain of CORDIC iterations
	for (genvar i = 0; i < ITER; i++) begin : g_cell
		ctp_cell #(
			.XW    (XW),
			.SHIFT (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cvalid[i]),
			.in_ready  (cready[i]),
			.in_x      (cx[i]),
			.in_y      (cy[i]),
			.in_z      (cz[i]),
			.in_tag    (ctag[i]),
			.out_valid (cvalid[i+1]),
			.out_ready (cready[i+1]),
			.out_x     (cx[i+1]),
			.out_y     (cy[i+1]),
			.out_z     (cz[i+1]),
			.out_tag   (ctag[i+1])
		);
	end

	// gain correction, angle unfolding and output register
	ctp_post #(
		.XW (XW)
	) u_post (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (cvalid[ITER]),
		.in_ready    (cready[ITER]),
		.in_x        (cx[ITER]),
		.in_z        (cz[ITER]),
		.in_tag      (ctag[ITER]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_modulus (modulus),
		.out_angle   (angle),
		.out_zero    (m_tuser)
	);

	assign m_tdata = {angle, modulus};

endmodule
